// File: design/vector_distance_metric_unit_top_defines.svh
// assertion macros for the distance unit checker
`ifndef VECTOR_DISTANCE_METRIC_UNIT_TOP_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define VDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("distance unit assertion failed");

// next-cycle implication, off during reset
`define VDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("distance unit assertion failed");

`endif

// File: design/vdm_pkg.sv
`default_nettype none
package vdm_pkg;

    localparam int ACC_W       = 48;
    localparam int DIST_W      = 47;
    localparam int ROOT_W      = ACC_W / 2;
    localparam int MAX_DIM_DEF = 4096;
    localparam int JOBQ_DEPTH  = 2;
    localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);

    localparam logic [ACC_W-1:0] UACC_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] OUT_LIM_U = 48'd35184372088832;
    localparam logic signed [ACC_W:0] OUT_LIM_S = 49'sd35184372088832;
    localparam logic [17:0] Q16_ONE = 18'd65536;

    typedef enum logic [1:0] {
        MT_SQ_L2 = 2'd0,
        MT_L2    = 2'd1,
        MT_COS   = 2'd2,
        MT_IP    = 2'd3
    } t_metric;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DECODE,
        BK_ROOT_L2,
        BK_ROOT_A,
        BK_ROOT_B,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_FIN
    } t_back_state;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     degenerate;
    } t_out_beat;

    typedef struct packed {
        logic [ACC_W-1:0]        sum_sq_diff;
        logic signed [ACC_W-1:0] dot_acc;
        logic [ACC_W-1:0]        norm_a_acc;
        logic [ACC_W-1:0]        norm_b_acc;
    } t_job;

    typedef struct packed {
        logic                  head_valid;
        logic [JOBQ_CNT_W-1:0] count;
    } t_jobq_status;

endpackage
`default_nettype wire

// File: design/vdm_front.sv
`default_nettype none
module vdm_front #(
    parameter int MAX_DIM = vdm_pkg::MAX_DIM_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire vdm_pkg::t_in_beat    i_in_beat,
    input  wire vdm_pkg::t_jobq_status i_q_stat,
    output logic                      o_job_push,
    output vdm_pkg::t_job             o_job
);
    import vdm_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic               accept;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_s1_valid;
    logic               r_s1_last;
    logic               r_s1_use;
    logic [32:0]        r_p_sq;
    logic [30:0]        r_p_aa;
    logic [30:0]        r_p_bb;
    logic signed [31:0] r_p_ab;

    logic signed [16:0] diff;
    logic signed [33:0] m_sq;
    logic signed [31:0] m_aa;
    logic signed [31:0] m_bb;
    logic signed [31:0] m_ab;

    logic [ACC_W-1:0]        r_ssd, r_na, r_nb;
    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        n_ssd, n_na, n_nb;
    logic signed [ACC_W-1:0] n_dot;
    logic [ACC_W:0]          s_ssd, s_na, s_nb;
    logic signed [ACC_W:0]   s_dot;

    assign full = (i_q_stat.count == JOBQ_CNT_W'(JOBQ_DEPTH)) ||
                  ((i_q_stat.count == JOBQ_CNT_W'(JOBQ_DEPTH - 1)) && r_s1_valid && r_s1_last);
    assign accept = push && !full;

    assign diff = 17'(i_in_beat.elem_a) - 17'(i_in_beat.elem_b);
    assign m_sq = 34'(diff) * 34'(diff);
    assign m_aa = 32'(i_in_beat.elem_a) * 32'(i_in_beat.elem_a);
    assign m_bb = 32'(i_in_beat.elem_b) * 32'(i_in_beat.elem_b);
    assign m_ab = 32'(i_in_beat.elem_a) * 32'(i_in_beat.elem_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (i_in_beat.last) begin
                    r_cnt <= '0;
                end else if (r_cnt < CNT_W'(MAX_DIM)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_in_beat.last;
            r_s1_use  <= (r_cnt < CNT_W'(MAX_DIM));
            r_p_sq    <= m_sq[32:0];
            r_p_aa    <= m_aa[30:0];
            r_p_bb    <= m_bb[30:0];
            r_p_ab    <= m_ab;
        end
    end

    // saturating accumulate
    always_comb begin
        s_ssd = {1'b0, r_ssd} + (ACC_W + 1)'(r_p_sq);
        s_na  = {1'b0, r_na} + (ACC_W + 1)'(r_p_aa);
        s_nb  = {1'b0, r_nb} + (ACC_W + 1)'(r_p_bb);
        s_dot = {r_dot[ACC_W-1], r_dot} + (ACC_W + 1)'(r_p_ab);
        n_ssd = s_ssd[ACC_W] ? UACC_MAX : s_ssd[ACC_W-1:0];
        n_na  = s_na[ACC_W] ? UACC_MAX : s_na[ACC_W-1:0];
        n_nb  = s_nb[ACC_W] ? UACC_MAX : s_nb[ACC_W-1:0];
        if (s_dot[ACC_W] != s_dot[ACC_W-1]) begin
            n_dot = s_dot[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_dot = s_dot[ACC_W-1:0];
        end
        if (!r_s1_use) begin
            n_ssd = r_ssd;
            n_na  = r_na;
            n_nb  = r_nb;
            n_dot = r_dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssd <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_dot <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_ssd <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_dot <= '0;
            end else begin
                r_ssd <= n_ssd;
                r_na  <= n_na;
                r_nb  <= n_nb;
                r_dot <= n_dot;
            end
        end
    end

    assign o_job_push        = r_s1_valid && r_s1_last;
    assign o_job.sum_sq_diff = n_ssd;
    assign o_job.dot_acc     = n_dot;
    assign o_job.norm_a_acc  = n_na;
    assign o_job.norm_b_acc  = n_nb;

endmodule
`default_nettype wire

// File: design/vdm_jobq.sv
`default_nettype none
module vdm_jobq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire vdm_pkg::t_job         i_job,
    input  wire logic                  i_pop,
    output vdm_pkg::t_job              o_job,
    output vdm_pkg::t_jobq_status      o_stat
);
    import vdm_pkg::*;

    localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

    t_job                  r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      r_rp;
    logic [JOBQ_CNT_W-1:0] r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job             = r_mem[r_rp];
    assign o_stat.head_valid = (r_count != '0);
    assign o_stat.count      = r_count;

endmodule
`default_nettype wire

// File: design/vdm_isqrt.sv
`default_nettype none
module vdm_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [vdm_pkg::ACC_W-1:0]   i_operand,
    output logic                             o_done,
    output logic [vdm_pkg::ROOT_W-1:0]       o_root
);
    import vdm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [ACC_W-1:0]   r_op;
    logic [ROOT_W+1:0]  r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [ROOT_W+1:0]  rem_sh;
    logic [ROOT_W+1:0]  trial;
    logic               ge;

    // two bits of the radicand per step
    assign rem_sh = {r_rem[ROOT_W-1:0], r_op[ACC_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(ROOT_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_op   <= {r_op[ACC_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// File: design/vdm_back.sv
`default_nettype none
module vdm_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_wdata,
    input  wire vdm_pkg::t_jobq_status i_q_stat,
    input  wire vdm_pkg::t_job         i_job,
    output logic                       o_job_pop,
    output logic                       empty,
    input  wire logic                  pop,
    output vdm_pkg::t_out_beat         o_out_beat
);
    import vdm_pkg::*;

    t_metric          r_metric;
    t_back_state      r_state, n_state;
    t_job             r_job;
    logic             r_out_valid;
    t_out_beat        r_out;
    logic [ROOT_W-1:0] r_ra, r_rb;
    logic [ACC_W-1:0] r_den;
    logic [63:0]      r_num;
    logic [ACC_W-1:0] r_rem;
    logic [5:0]       r_div_cnt;

    logic             sq_start;
    logic [ACC_W-1:0] sq_operand;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic             res_load;
    t_out_beat        n_res;
    logic             job_degen;
    logic [ACC_W-1:0] mag;
    logic signed [ACC_W:0] neg_dot;
    logic [ACC_W:0]   rem_sh;
    logic             div_ge;
    logic [16:0]      q_clamp;
    logic [17:0]      cos_dist;

    vdm_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (sq_operand),
        .o_done    (sq_done),
        .o_root    (sq_root)
    );

    assign job_degen = (r_job.norm_a_acc == '0) || (r_job.norm_b_acc == '0);
    assign mag = r_job.dot_acc[ACC_W-1] ? ACC_W'(-r_job.dot_acc) : ACC_W'(r_job.dot_acc);
    assign neg_dot = -{r_job.dot_acc[ACC_W-1], r_job.dot_acc};
    assign rem_sh = {r_rem, r_num[63]};
    assign div_ge = (rem_sh >= {1'b0, r_den});
    assign q_clamp = (r_num > 64'(Q16_ONE)) ? 17'(Q16_ONE) : r_num[16:0];
    assign cos_dist = r_job.dot_acc[ACC_W-1] ? Q16_ONE + 18'(q_clamp)
                                             : Q16_ONE - 18'(q_clamp);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:    if (o_job_pop) n_state = BK_DECODE;
            BK_DECODE: begin
                case (r_metric)
                    MT_L2:   n_state = BK_ROOT_L2;
                    MT_COS:  n_state = job_degen ? BK_IDLE : BK_ROOT_A;
                    default: n_state = BK_IDLE;
                endcase
            end
            BK_ROOT_L2: if (sq_done) n_state = BK_IDLE;
            BK_ROOT_A:  if (sq_done) n_state = BK_ROOT_B;
            BK_ROOT_B:  if (sq_done) n_state = BK_MUL;
            BK_MUL:     n_state = BK_PREP;
            BK_PREP:    n_state = BK_DIV;
            BK_DIV:     if (r_div_cnt == 6'd63) n_state = BK_FIN;
            BK_FIN:     n_state = BK_IDLE;
            default:    n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = 1'b0;
        sq_start   = 1'b0;
        sq_operand = r_job.sum_sq_diff;
        res_load   = 1'b0;
        n_res      = '0;
        case (r_state)
            BK_IDLE: o_job_pop = i_q_stat.head_valid && !r_out_valid;
            BK_DECODE: begin
                case (r_metric)
                    MT_SQ_L2: begin
                        res_load = 1'b1;
                        n_res.distance = (r_job.sum_sq_diff > OUT_LIM_U) ?
                            DIST_W'(OUT_LIM_U) : DIST_W'(r_job.sum_sq_diff);
                    end
                    MT_L2: sq_start = 1'b1;
                    MT_COS: begin
                        if (job_degen) begin
                            res_load         = 1'b1;
                            n_res.distance   = DIST_W'(Q16_ONE);
                            n_res.degenerate = 1'b1;
                        end else begin
                            sq_start   = 1'b1;
                            sq_operand = r_job.norm_a_acc;
                        end
                    end
                    default: begin
                        res_load = 1'b1;
                        if (neg_dot > OUT_LIM_S) begin
                            n_res.distance = DIST_W'(OUT_LIM_S);
                        end else if (neg_dot < -OUT_LIM_S) begin
                            n_res.distance = DIST_W'(-OUT_LIM_S);
                        end else begin
                            n_res.distance = DIST_W'(neg_dot);
                        end
                    end
                endcase
            end
            BK_ROOT_L2: begin
                res_load       = sq_done;
                n_res.distance = DIST_W'(sq_root);
            end
            BK_ROOT_A: begin
                sq_start   = sq_done;
                sq_operand = r_job.norm_b_acc;
            end
            BK_FIN: begin
                res_load       = 1'b1;
                n_res.distance = DIST_W'(cos_dist);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_metric    <= MT_SQ_L2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_metric <= t_metric'(i_cfg_wdata);
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (res_load) begin
            r_out <= n_res;
        end
        if (r_state == BK_ROOT_A && sq_done) begin
            r_ra <= sq_root;
        end
        if (r_state == BK_ROOT_B && sq_done) begin
            r_rb <= sq_root;
        end
        if (r_state == BK_MUL) begin
            r_den <= ACC_W'(r_ra) * ACC_W'(r_rb);
        end
        if (r_state == BK_PREP) begin
            r_num     <= {mag, 16'b0} + 64'(r_den >> 1);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        // restoring divide, quotient shifts into the numerator register
        if (r_state == BK_DIV) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            r_rem     <= div_ge ? ACC_W'(rem_sh - {1'b0, r_den}) : rem_sh[ACC_W-1:0];
            r_num     <= {r_num[62:0], div_ge};
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_beat = r_out;

endmodule
`default_nettype wire

// File: design/vector_distance_metric_unit_top.sv
// channel   direction  handshake        payload
// input     in         push / full      i_in_beat  (elem_a, elem_b, last)
// result    out        empty / pop      o_out_beat (distance, degenerate)
// config    in         i_cfg_we         i_cfg_wdata (metric)
//
// one element pair is taken per cycle while full is low
// squared l2 and inner product results come straight from the finished job; l2 passes through
// the 24-step root unit, and cosine through it twice and then the 64-step divider
// the job queue holds two finished vectors; input stalls once both slots are taken or claimed
// reset is synchronous and active low; no clearing pass follows it
`default_nettype none
module vector_distance_metric_unit_top #(
    parameter int MAX_DIM = vdm_pkg::MAX_DIM_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire vdm_pkg::t_in_beat  i_in_beat,
    output logic                    empty,
    input  wire logic               pop,
    output vdm_pkg::t_out_beat      o_out_beat,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_wdata
);
    import vdm_pkg::*;

    t_jobq_status q_stat;
    t_job         push_job;
    t_job         head_job;
    logic         job_push;
    logic         job_pop;

    vdm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_beat  (i_in_beat),
        .i_q_stat   (q_stat),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    vdm_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    vdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire

// File: design/vdm_checker.sv
`default_nettype none
`include "vector_distance_metric_unit_top_defines.svh"
module vdm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire vdm_pkg::t_out_beat o_out_beat
);
    import vdm_pkg::*;

    // a waiting result holds until popped
    `VDM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, (!empty && !pop), (!empty && $stable(o_out_beat)))

    // nothing waits and nothing is full right after reset
    `VDM_ASSERT_IMPL(a_rst, i_clk, i_rst_n, $past(!i_rst_n), (empty && !full))

    // zero norm gives exactly one
    `VDM_ASSERT_IMPL(a_degen, i_clk, i_rst_n, (!empty && o_out_beat.degenerate),
        (o_out_beat.distance == 47'sd65536))

endmodule

bind vector_distance_metric_unit_top vdm_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_beat (o_out_beat)
);
`default_nettype wire
